### rtl/hdec_pkg.sv
// Shared types for the Huffman tree byte decoder: item payloads and queue commands.
package hdec_pkg;

    localparam int CODE_W  = 9;
    localparam int ENTRY_W = 2 * CODE_W;
    localparam int LEN_W   = 24;

    typedef struct packed {
        logic               func;
        logic [7:0]         node_index;
        logic [CODE_W-1:0]  branch_zero;
        logic [CODE_W-1:0]  branch_one;
        logic [7:0]         data_byte;
        logic               first_of_chunk;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         node;
        logic [ENTRY_W-1:0] entry;
        logic [7:0]         data;
        logic               first;
    } cmd_t;

endpackage

### rtl/hdec_front.sv
// Front end: accepts input items, classifies them, drops table writes beyond the node table and queues commands.
module hdec_front #(
    parameter int NODE_COUNT = 255
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hdec_pkg::in_item_t in_item,
    output logic             q_valid,
    output hdec_pkg::cmd_t   q_cmd,
    input  logic             q_pop
);
    import hdec_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cmd_t          fifo_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          keep;
    logic          push;
    cmd_t          cmd_in;

    assign in_ready = (count_reg != CW'(DEPTH));
    assign keep     = in_item.func || (in_item.node_index < 8'(NODE_COUNT));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op    = in_item.func ? OP_DATA : OP_WRITE;
        cmd_in.node  = in_item.node_index;
        cmd_in.entry = {in_item.branch_one, in_item.branch_zero};
        cmd_in.data  = in_item.data_byte;
        cmd_in.first = in_item.first_of_chunk;
    end

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### rtl/hdec_back.sv
// Back end: node table memory, bit-serial tree walk, chunk byte count and output register.
module hdec_back #(
    parameter int NODE_COUNT = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hdec_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    input  logic               cfg_valid,
    input  logic [23:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hdec_pkg::out_item_t out_item
);
    import hdec_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam logic [AW-1:0] HEAD = AW'(NODE_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    logic [ENTRY_W-1:0] mem [NODE_COUNT];

    state_t             state_reg, state_next;
    logic [AW-1:0]      cur_node_reg, cur_node_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]   exp_len_reg;
    logic [7:0]         shift_reg, shift_next;
    logic [2:0]         bit_cnt_reg, bit_cnt_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic               pop_data;
    logic               pop_write;
    logic               in_step;
    logic               lit;
    logic               slot_free;
    logic               advance;
    logic               out_load;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      step_next;
    logic [CODE_W-1:0]  code;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign pop_data  = q_pop && (q_cmd.op == OP_DATA);
    assign pop_write = q_pop && (q_cmd.op == OP_WRITE);
    assign in_step   = (state_reg == ST_STEP) && (bytes_left_reg != '0);
    assign code      = shift_reg[0] ? rd_data_reg[ENTRY_W-1:CODE_W] : rd_data_reg[CODE_W-1:0];
    assign lit       = !code[CODE_W-1];
    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = in_step && (!lit || slot_free);
    assign out_load  = advance && lit;
    assign rd_en     = pop_data || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        if (lit || (code[7:0] >= 8'(NODE_COUNT)))
        begin
            step_next = HEAD;
        end
        else
        begin
            step_next = code[AW-1:0];
        end
    end

    always_comb
    begin
        rd_addr = step_next;
        if (state_reg == ST_IDLE)
        begin
            rd_addr = q_cmd.first ? HEAD : cur_node_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        bytes_left_next = bytes_left_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_data)
                begin
                    shift_next   = q_cmd.data;
                    bit_cnt_next = '0;
                    state_next   = ST_STEP;
                    if (q_cmd.first)
                    begin
                        cur_node_next   = HEAD;
                        bytes_left_next = exp_len_reg;
                    end
                end
            end
            ST_STEP:
            begin
                if (bytes_left_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (advance)
                begin
                    cur_node_next = step_next;
                    shift_next    = shift_reg >> 1;
                    bit_cnt_next  = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                    if (lit)
                    begin
                        bytes_left_next        = bytes_left_reg - LEN_W'(1);
                        out_valid_next         = 1'b1;
                        out_item_next.out_byte = code[7:0];
                        out_item_next.last     = (bytes_left_reg == LEN_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_node_reg   <= HEAD;
            bytes_left_reg <= '0;
            exp_len_reg    <= '0;
            bit_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            bytes_left_reg <= bytes_left_next;
            bit_cnt_reg    <= bit_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                exp_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop_write)
        begin
            mem[q_cmd.node[AW-1:0]] <= q_cmd.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_done_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && bytes_left_reg == '0) |=> (state_reg == ST_IDLE))
        else $error("walk continued with no bytes left");

    a_node_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_node_reg <= HEAD))
        else $error("current node beyond table");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten before transfer");

    a_last_ends_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && bytes_left_reg == LEN_W'(1)) |=> (bytes_left_reg == '0 && out_item_reg.last))
        else $error("last byte does not close the chunk");
`endif

endmodule

### rtl/huffman_tree_byte_decoder_core.sv
// Top level of the Huffman tree byte decoder: command queue front and tree walk back.
// Table write item: written to the node table as the walker pops it from the two-entry queue.
// Data byte item: one node table read plus up to eight bit steps, each a dependent table read;
// the walker pops no new item until they are done; a byte-emitting step waits for a free output
// slot. A decoded byte passes the queue, the table read register and the output register.
// Reset clears control, byte count and length; the node table is undefined until written.
module huffman_tree_byte_decoder_core #(
    parameter int NODE_COUNT = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hdec_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hdec_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);
    import hdec_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    hdec_front #(
        .NODE_COUNT(NODE_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    hdec_back #(
        .NODE_COUNT(NODE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

### tb/tb.sv
// Testbench for the Huffman tree byte decoder: tree loads, chunked byte streams, scoreboard.
`timescale 1ns / 1ps

module tb;
    import hdec_pkg::*;

    localparam int          NODE_COUNT    = 255;
    localparam logic [7:0]  HEAD_NODE     = 8'(NODE_COUNT - 1);
    localparam int          LITERAL_LIMIT = 256;
    localparam logic [8:0]  MISSING_CODE  = 9'h1FF;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          PHASES        = 9;
    localparam int          PHASE_ITEMS   = 33;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    class byte_decode_ledger;
        logic [17:0] node_tree [NODE_COUNT];
        int          known_nodes [$];
        logic [7:0]  walk_node;
        logic [23:0] bytes_left;
        logic [23:0] chunk_length;
        out_item_t   pending_bytes [$];
        int          mismatches;
        int          compared;
        int          tree_writes;
        int          data_bytes;
        int          length_settings;

        function new();
            foreach (node_tree[i]) node_tree[i] = '0;
            walk_node       = HEAD_NODE;
            bytes_left      = '0;
            chunk_length    = '0;
            mismatches      = 0;
            compared        = 0;
            tree_writes     = 0;
            data_bytes      = 0;
            length_settings = 0;
        endfunction

        function void set_length(logic [23:0] len);
            chunk_length = len;
            length_settings++;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void take_item(in_item_t it);
            logic [17:0] entry;
            logic [8:0]  code;
            int          next_node;
            out_item_t   decoded;
            if (it.func == OP_WRITE) begin
                tree_writes++;
                if (it.node_index < NODE_COUNT) begin
                    if (!(it.node_index inside {known_nodes}))
                        known_nodes.push_back(it.node_index);
                    node_tree[it.node_index] = {it.branch_one, it.branch_zero};
                end
                return;
            end
            data_bytes++;
            if (it.first_of_chunk) begin
                walk_node  = HEAD_NODE;
                bytes_left = chunk_length;
            end
            for (int k = 0; k < 8; k++) begin
                if (bytes_left == 0)
                    break;
                entry = node_tree[walk_node];
                code  = it.data_byte[k] ? entry[17:9] : entry[8:0];
                if (code < LITERAL_LIMIT) begin
                    bytes_left       = bytes_left - 1'b1;
                    decoded.out_byte = code[7:0];
                    decoded.last     = (bytes_left == 0);
                    pending_bytes.push_back(decoded);
                    walk_node = HEAD_NODE;
                end else begin
                    next_node = int'(code) - LITERAL_LIMIT;
                    walk_node = (next_node < NODE_COUNT) ? 8'(next_node) : HEAD_NODE;
                end
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task match_byte(out_item_t got);
            out_item_t want;
            compared++;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("byte %02h, expected %02h", got.out_byte, want.out_byte));
            if (got.last !== want.last)
                report($sformatf("last %0b on byte %02h, expected %0b",
                                 got.last, got.out_byte, want.last));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = '0;

    byte_decode_ledger sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    huffman_tree_byte_decoder_core #(
        .NODE_COUNT(NODE_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.match_byte(out_item);
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #1500000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.take_item(it);
    endtask

    task automatic write_length(input logic [23:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_length(len);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 67; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 67; end
            default:   begin send_idle_pct = 16; stall_pct = 16; end
        endcase
    endtask

    function automatic in_item_t make_item(input op_t op, input logic [7:0] idx,
                                           input logic [8:0] b0, input logic [8:0] b1,
                                           input logic [7:0] data, input logic first);
        in_item_t it;
        it.func           = op;
        it.node_index     = idx;
        it.branch_zero    = b0;
        it.branch_one     = b1;
        it.data_byte      = data;
        it.first_of_chunk = first;
        return it;
    endfunction

    function automatic logic [8:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return MISSING_CODE;
        if (roll < 50 && sb.known_nodes.size() > 0)
            return 9'(LITERAL_LIMIT
                      + sb.known_nodes[$urandom_range(0, sb.known_nodes.size() - 1)]);
        return 9'($urandom_range(0, LITERAL_LIMIT - 1));
    endfunction

    initial
    begin
        in_item_t    it;
        logic [63:0] raw;
        logic [23:0] lengths [PHASES];
        idle_mode_t  modes [PHASES];
        int          roll;
        int          pick;
        int          chunk_left;

        sb = new();
        lengths = '{24'd7, 24'd0, 24'hFFFFFF, 24'd1, 24'd3, 24'd0, 24'd40, 24'd0, 24'd16};
        lengths[5] = 24'($urandom_range(2, 20));
        lengths[7] = 24'($urandom_range(1, 10));
        modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
                  IDLE_BOTH, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_idle(IDLE_NONE);
        write_length(24'd5);
        send_item(make_item(OP_WRITE, 8'hFF, MISSING_CODE, MISSING_CODE, 8'hFF, 1'b1));
        send_item(make_item(OP_WRITE, 8'd0, 9'h000, 9'h0FF, 8'h00, 1'b1));
        send_item(make_item(OP_WRITE, 8'd1, 9'h100, MISSING_CODE, 8'h00, 1'b0));
        send_item(make_item(OP_WRITE, HEAD_NODE, 9'h101, 9'h080, 8'h00, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'hFF, 1'b0));
        send_item(make_item(OP_DATA, 8'hFF, 9'h1FF, 9'h1FF, 8'hFF, 1'b1));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'h00, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'h00, 1'b1));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'hA5, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'h5A, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'h02, 1'b0));
        send_item(make_item(OP_WRITE, HEAD_NODE, 9'h1FE, MISSING_CODE, 8'h00, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'h3C, 1'b1));
        send_item(make_item(OP_WRITE, HEAD_NODE, 9'h101, 9'h055, 8'h00, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'h96, 1'b1));
        send_item(make_item(OP_WRITE, 8'd2, MISSING_CODE, 9'h0AA, 8'h00, 1'b0));
        send_item(make_item(OP_WRITE, HEAD_NODE, 9'h102, 9'h1FE, 8'h00, 1'b0));
        send_item(make_item(OP_DATA, 8'h00, 9'h000, 9'h000, 8'hC3, 1'b1));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_length(lengths[p]);
            apply_idle(modes[p]);
            chunk_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                raw  = {$urandom, $urandom};
                it   = raw[$bits(in_item_t)-1:0];
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    it.func = OP_WRITE;
                    pick = $urandom_range(0, 99);
                    if (pick < 65)
                        it.node_index = 8'($urandom_range(0, 15));
                    else if (pick < 80)
                        it.node_index = HEAD_NODE;
                    else if (pick < 92)
                        it.node_index = 8'($urandom_range(0, 255));
                    else
                        it.node_index = 8'hFF;
                    it.branch_zero = pick_code();
                    it.branch_one  = pick_code();
                end else begin
                    it.func = OP_DATA;
                    if (roll < 20) begin
                        it.first_of_chunk = 1'($urandom_range(0, 1));
                    end else if (chunk_left == 0) begin
                        it.first_of_chunk = 1'b1;
                        chunk_left = $urandom_range(1, 10);
                    end else begin
                        it.first_of_chunk = 1'b0;
                        chunk_left--;
                    end
                end
                send_item(it);
            end
        end
        settle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d decoded bytes never arrived", sb.pending()));
        $display("Covered %0d tree writes and %0d data bytes over %0d length settings.",
                 sb.tree_writes, sb.data_bytes, sb.length_settings);
        $display("Compared %0d decoded bytes, %0d mismatches.", sb.compared, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
rtl/hdec_pkg.sv
rtl/hdec_front.sv
rtl/hdec_back.sv
rtl/huffman_tree_byte_decoder_core.sv
tb/tb.sv
